// ===== hw/rtl/tcrq_pkg.sv =====
// ============================================================================
// Three-class ready queue package
// Shared beat types, request and status codes, and field widths.
// ============================================================================
package tcrq_pkg;

    // Field widths of the request and response beats.
    localparam int TAG_W   = 16;
    localparam int CNT_W   = 8;
    localparam int IDX_W   = 5;
    localparam int READY_W = 6;

    // Default number of entries in each queue.
    localparam int QUEUE_DEPTH_DEF = 16;

    // Request codes.
    localparam logic [1:0] REQ_ENQ  = 2'd0;
    localparam logic [1:0] REQ_DEQ  = 2'd1;
    localparam logic [1:0] REQ_PEEK = 2'd2;

    // Status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    // Queue identifiers, also used as the source code of a response.
    localparam logic [1:0] Q_PRIO   = 2'd0;
    localparam logic [1:0] Q_NORMAL = 2'd1;
    localparam logic [1:0] Q_MARKER = 2'd2;
    localparam logic [1:0] Q_NONE   = 2'd3;

    localparam int NUM_Q = 3;

    // Request beat.
    typedef struct packed {
        logic [1:0]       req_type;
        logic [TAG_W-1:0] task_tag;
        logic             is_marker;
        logic [CNT_W-1:0] cmd_count;
        logic [CNT_W-1:0] memcpy_count;
        logic             device_free;
        logic [IDX_W-1:0] peek_index;
    } tcrq_req_t;

    // Response beat.
    typedef struct packed {
        logic [1:0]         status;
        logic [TAG_W-1:0]   tag_out;
        logic [1:0]         source_queue;
        logic [READY_W-1:0] ready_count;
        logic               ready_empty;
    } tcrq_rsp_t;

    // Per-queue control for one accepted request.
    typedef struct packed {
        logic             push;
        logic             pop;
        logic             rd_en;
        logic [IDX_W-1:0] rd_offset;
    } tcrq_fifo_ctl_t;

endpackage

// ===== hw/rtl/tcrq_fifo.sv =====
// ============================================================================
// Three-class ready queue: single FIFO
// Circular tag store with head pointer and fill count. A read at an offset
// from the head lands in a registered read data word.
// ============================================================================
module tcrq_fifo #(
    parameter int QUEUE_DEPTH = tcrq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  tcrq_pkg::tcrq_fifo_ctl_t       ctl,
    input  logic [tcrq_pkg::TAG_W-1:0]     wr_tag,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0] fill,
    output logic [tcrq_pkg::TAG_W-1:0]     rdata
);
    import tcrq_pkg::*;

    localparam int AW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FW   = $clog2(QUEUE_DEPTH+1);
    localparam int SUMW = ((AW > IDX_W) ? AW : IDX_W) + 2;
    localparam logic [SUMW-1:0] DEPTH_S = SUMW'(QUEUE_DEPTH);

    logic [TAG_W-1:0] mem [QUEUE_DEPTH];
    logic [TAG_W-1:0] rdata_reg;
    logic [AW-1:0]    head_reg, head_next;
    logic [FW-1:0]    fill_reg, fill_next;
    logic [SUMW-1:0]  rd_sum, wr_sum;
    logic [AW-1:0]    rd_addr, wr_addr;

    // Read slot: head plus offset, wrapped once.
    always_comb
    begin
        rd_sum = SUMW'(head_reg) + SUMW'(ctl.rd_offset);
        if (rd_sum >= DEPTH_S)
        begin
            rd_sum = rd_sum - DEPTH_S;
        end
        rd_addr = rd_sum[AW-1:0];
    end

    // Write slot: head plus fill count, wrapped once.
    always_comb
    begin
        wr_sum = SUMW'(head_reg) + SUMW'(fill_reg);
        if (wr_sum >= DEPTH_S)
        begin
            wr_sum = wr_sum - DEPTH_S;
        end
        wr_addr = wr_sum[AW-1:0];
    end

    // Pointer updates; push and pop never come together.
    always_comb
    begin
        head_next = head_reg;
        fill_next = fill_reg;
        if (ctl.push)
        begin
            fill_next = fill_reg + FW'(1);
        end
        else if (ctl.pop)
        begin
            fill_next = fill_reg - FW'(1);
            if (head_reg == AW'(QUEUE_DEPTH - 1))
            begin
                head_next = '0;
            end
            else
            begin
                head_next = head_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            fill_reg <= fill_next;
        end
    end

    // Tag store with one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            mem[wr_addr] <= wr_tag;
        end
        if (ctl.rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    assign fill  = fill_reg;
    assign rdata = rdata_reg;

`ifndef ASSERT_OFF
    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FW'(QUEUE_DEPTH))
    else $error("FIFO fill count exceeds depth.");

    assert property (@(posedge clk) disable iff (!rst_n)
        ctl.push |-> fill_reg != FW'(QUEUE_DEPTH))
    else $error("Push into a full FIFO.");

    assert property (@(posedge clk) disable iff (!rst_n)
        ctl.pop |-> fill_reg != '0 && !ctl.push)
    else $error("Pop from an empty FIFO or together with a push.");
`endif

endmodule

// ===== hw/rtl/three_class_ready_queue.sv =====
// ============================================================================
// Three-class ready queue
// Priority, normal and marker task FIFOs with strict-priority dequeue and
// indexed peek across the priority and normal FIFOs.
// ============================================================================
//  channel | direction | handshake            | beat
//  --------+-----------+----------------------+------------
//  req     | in        | req_valid, req_ready | tcrq_req_t
//  rsp     | out       | rsp_valid, rsp_ready | tcrq_rsp_t
//
// Each request is decided in the cycle it is accepted and its response is
// presented in the next cycle from the response register and the FIFO read
// data registers; one request per cycle is sustained while rsp is not stalled.
// req_ready is high whenever the response register is empty or being taken,
// so a stall on rsp holds at most one response and stops further requests.
// Reset clears the head pointers, fill counts and the response valid flag.
// ============================================================================
module three_class_ready_queue #(
    parameter int QUEUE_DEPTH = tcrq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  tcrq_pkg::tcrq_req_t req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output tcrq_pkg::tcrq_rsp_t rsp
);
    import tcrq_pkg::*;

    localparam int FW  = $clog2(QUEUE_DEPTH+1);
    localparam int SW  = ((FW + 1) > (IDX_W + 1)) ? (FW + 1) : (IDX_W + 1);
    localparam int RCW = ((FW + 1) > READY_W) ? (FW + 1) : READY_W;

    tcrq_fifo_ctl_t   fifo_ctl [NUM_Q];
    logic [FW-1:0]    fill     [NUM_Q];
    logic [TAG_W-1:0] rdata    [NUM_Q];

    logic             accept;
    logic [1:0]       status_c, src_c;
    logic             from_mem_c;
    logic [SW-1:0]    idx_s, pf_s, ready_s;
    logic [RCW-1:0]   count_c;
    logic [IDX_W-1:0] norm_off;
    logic             tgt_full;

    logic             rsp_valid_reg;
    logic [1:0]       status_reg, src_reg;
    logic             from_mem_reg;
    logic [READY_W-1:0] count_reg;
    logic             empty_reg;
    logic [TAG_W-1:0] tag_sel;

    assign accept    = req_valid && req_ready;
    assign req_ready = !rsp_valid_reg || rsp_ready;

    assign idx_s    = SW'(req.peek_index);
    assign pf_s     = SW'(fill[Q_PRIO]);
    assign ready_s  = SW'(fill[Q_PRIO]) + SW'(fill[Q_NORMAL]);
    assign norm_off = IDX_W'(idx_s - pf_s);

    // Request decode: route, queue controls and response fields.
    always_comb
    begin
        status_c   = ST_OK;
        src_c      = Q_NONE;
        from_mem_c = 1'b0;
        tgt_full   = 1'b0;
        for (int q = 0; q < NUM_Q; q++)
        begin
            fifo_ctl[q] = '0;
        end
        case (req.req_type)
            REQ_ENQ:
            begin
                if (req.is_marker)
                begin
                    src_c = Q_MARKER;
                end
                else if (req.memcpy_count == req.cmd_count)
                begin
                    src_c = Q_PRIO;
                end
                else
                begin
                    src_c = Q_NORMAL;
                end
                tgt_full = (fill[src_c] == FW'(QUEUE_DEPTH));
                if (tgt_full)
                begin
                    status_c = ST_FULL;
                end
                else
                begin
                    fifo_ctl[src_c].push = accept;
                end
            end
            REQ_DEQ:
            begin
                if (fill[Q_PRIO] != '0)
                begin
                    src_c = Q_PRIO;
                end
                else if (fill[Q_NORMAL] != '0)
                begin
                    src_c = Q_NORMAL;
                end
                else if (fill[Q_MARKER] != '0 && req.device_free)
                begin
                    src_c = Q_MARKER;
                end
                if (src_c == Q_NONE)
                begin
                    status_c = ST_EMPTY;
                end
                else
                begin
                    from_mem_c           = 1'b1;
                    fifo_ctl[src_c].pop   = accept;
                    fifo_ctl[src_c].rd_en = accept;
                end
            end
            REQ_PEEK:
            begin
                if (idx_s < pf_s)
                begin
                    src_c                       = Q_PRIO;
                    from_mem_c                  = 1'b1;
                    fifo_ctl[Q_PRIO].rd_en      = accept;
                    fifo_ctl[Q_PRIO].rd_offset  = req.peek_index;
                end
                else if (idx_s < ready_s)
                begin
                    src_c                       = Q_NORMAL;
                    from_mem_c                  = 1'b1;
                    fifo_ctl[Q_NORMAL].rd_en     = accept;
                    fifo_ctl[Q_NORMAL].rd_offset = norm_off;
                end
                else
                begin
                    status_c = ST_RANGE;
                end
            end
            default:
            begin
                status_c = ST_OK;
            end
        endcase
    end

    // Ready count after this request.
    always_comb
    begin
        count_c = RCW'(ready_s);
        if (fifo_ctl[Q_PRIO].push || fifo_ctl[Q_NORMAL].push)
        begin
            count_c = count_c + RCW'(1);
        end
        else if (fifo_ctl[Q_PRIO].pop || fifo_ctl[Q_NORMAL].pop)
        begin
            count_c = count_c - RCW'(1);
        end
    end

    // FIFOs, one per class.
    for (genvar g = 0; g < NUM_Q; g++)
    begin : g_fifo
        tcrq_fifo #(
            .QUEUE_DEPTH (QUEUE_DEPTH)
        ) u_fifo (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctl    (fifo_ctl[g]),
            .wr_tag (req.task_tag),
            .fill   (fill[g]),
            .rdata  (rdata[g])
        );
    end

    // Response valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (req_ready)
        begin
            rsp_valid_reg <= req_valid;
        end
    end

    // Response fields, captured with the request.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg   <= status_c;
            src_reg      <= src_c;
            from_mem_reg <= from_mem_c;
            count_reg    <= count_c[READY_W-1:0];
            empty_reg    <= (count_c == '0);
        end
    end

    // Tag word from the FIFO that served the request.
    always_comb
    begin
        case (src_reg)
            Q_PRIO:   tag_sel = rdata[Q_PRIO];
            Q_NORMAL: tag_sel = rdata[Q_NORMAL];
            Q_MARKER: tag_sel = rdata[Q_MARKER];
            default:  tag_sel = '0;
        endcase
    end

    assign rsp_valid        = rsp_valid_reg;
    assign rsp.status       = status_reg;
    assign rsp.tag_out      = from_mem_reg ? tag_sel : '0;
    assign rsp.source_queue = src_reg;
    assign rsp.ready_count  = count_reg;
    assign rsp.ready_empty  = empty_reg;

`ifndef ASSERT_OFF
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> rsp_valid)
    else $error("Accepted request produced no response beat.");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == ST_FULL |-> rsp.source_queue != Q_NONE)
    else $error("Full status without a target queue.");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == ST_EMPTY || rsp.status == ST_RANGE)
            |-> rsp.tag_out == '0 && rsp.source_queue == Q_NONE)
    else $error("Failed dequeue or peek carries a tag or source.");

    assert property (@(posedge clk) disable iff (!rst_n)
        $countones({fifo_ctl[Q_PRIO].rd_en, fifo_ctl[Q_NORMAL].rd_en,
                    fifo_ctl[Q_MARKER].rd_en}) <= 1)
    else $error("More than one FIFO read for a single request.");
`endif

endmodule
